>>> rtl/cvs_pkg.sv
// Shared types, widths and codes of the cyclic voltammetry sweep generator.
// Used by cvs_step, cyclic_voltammetry_sweep and cvs_checker; depends on nothing.
package cvs_pkg;

    // Field widths.
    localparam int POT_W      = 17;
    localparam int SAMPLE_W   = 12;
    localparam int STEP_W     = 16;
    localparam int CYCLE_W    = 8;
    localparam int PERIOD_W   = 16;
    localparam int COUNT_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Input beat layout: voltage then current, padded to whole bytes.
    localparam int S_OFF_VOLT  = 0;
    localparam int S_OFF_CURR  = SAMPLE_W;
    localparam int S_DATA_BITS = 2 * SAMPLE_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;

    // Result beat layout, lowest field first, padded to whole bytes.
    localparam int M_OFF_SETPOINT = 0;
    localparam int M_OFF_INDEX    = POT_W;
    localparam int M_OFF_TIME     = M_OFF_INDEX + COUNT_W;
    localparam int M_OFF_VOLT     = M_OFF_TIME + COUNT_W;
    localparam int M_OFF_CURR     = M_OFF_VOLT + SAMPLE_W;
    localparam int M_DATA_BITS    = M_OFF_CURR + SAMPLE_W;
    localparam int M_TDATA_W      = ((M_DATA_BITS + 7) / 8) * 8;

    // Command codes carried in s_tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_BEGIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CYCLES = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd5;

    // Target selector codes; the spare code behaves as the begin target.
    localparam logic [1:0] SEL_VERTEX1 = 2'd0;
    localparam logic [1:0] SEL_VERTEX2 = 2'd1;
    localparam logic [1:0] SEL_BEGIN   = 2'd2;

    // Sweep shape registers as seen by the step logic.
    typedef struct packed {
        logic [POT_W-1:0]   begin_pot;
        logic [POT_W-1:0]   vertex1;
        logic [POT_W-1:0]   vertex2;
        logic [STEP_W-1:0]  step;
        logic [CYCLE_W-1:0] cycle_total;
    } cvs_cfg_t;

    // Sweep position carried from one tick to the next.
    typedef struct packed {
        logic [POT_W-1:0]   setpoint;
        logic [1:0]         sel;
        logic               going_up;
        logic [CYCLE_W-1:0] cycle_index;
    } cvs_sweep_t;

endpackage

>>> rtl/cyclic_voltammetry_sweep.sv
// Triangular potential sweep generator: register file, sweep state and result register.
// Depends on cvs_pkg and cvs_step.
//
//  Port group  Direction  Carries
//  s_*         in         one beat per command: start, or tick with voltage and current
//  m_*         out        one beat per command: setpoint, point data, finished flag
//  p*          in/out     APB register access, six registers at byte addresses 0 to 20
//
// Every accepted beat yields its result beat in the next cycle; one beat per cycle is
// sustained while m_tready is high. The single pass through the target chain, step
// adder and 16x32 time multiplier sits between the accepted beat and the result register.
// s_tready stays high while the result register is empty or being emptied, so a
// stalled m_tready holds back the input after one beat. Reset is synchronous.
module cyclic_voltammetry_sweep (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cvs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cvs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cvs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cvs_pkg::S_TDATA_W-1:0]      s_tdata,   // voltage_sample, current_sample
    input  logic [0:0]                         s_tuser,   // command
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cvs_pkg::M_TDATA_W-1:0]      m_tdata,   // setpoint, point_index, time_ms,
                                                          // voltage_out, current_out
    output logic [0:0]                         m_tuser,   // sample_valid
    output logic                               m_tlast    // finished
);
    import cvs_pkg::*;

    localparam int PROD_W = PERIOD_W + COUNT_W;

    // Configuration registers.
    logic [POT_W-1:0]      begin_pot_reg;
    logic [POT_W-1:0]      vertex1_reg;
    logic [POT_W-1:0]      vertex2_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CYCLE_W-1:0]    cycle_total_reg;
    logic [PERIOD_W-1:0]   period_reg;

    // Sweep state.
    cvs_sweep_t            sweep_reg;
    cvs_sweep_t            sweep_next;
    logic [COUNT_W-1:0]    point_count_reg;
    logic [COUNT_W-1:0]    point_count_next;
    logic                  running_reg;
    logic                  running_next;

    // Result register.
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TDATA_W-1:0]  m_tdata_next;
    logic                  m_tuser_reg;
    logic                  m_tuser_next;
    logic                  m_tlast_reg;
    logic                  m_tlast_next;

    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  s_accept;
    cvs_cfg_t              cfg;
    cvs_sweep_t            tick_sweep;
    logic                  tick_finish;
    logic [PROD_W-1:0]     time_prod;
    logic [COUNT_W-1:0]    time_sat;
    logic [SAMPLE_W-1:0]   voltage_in;
    logic [SAMPLE_W-1:0]   current_in;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            begin_pot_reg   <= '0;
            vertex1_reg     <= '0;
            vertex2_reg     <= '0;
            step_reg        <= STEP_W'(100);
            cycle_total_reg <= CYCLE_W'(1);
            period_reg      <= PERIOD_W'(100);
        end else if (cfg_write) begin
            case (reg_idx)
                REG_BEGIN:   begin_pot_reg   <= pwdata[POT_W-1:0];
                REG_VERTEX1: vertex1_reg     <= pwdata[POT_W-1:0];
                REG_VERTEX2: vertex2_reg     <= pwdata[POT_W-1:0];
                REG_STEP:    step_reg        <= pwdata[STEP_W-1:0];
                REG_CYCLES:  cycle_total_reg <= pwdata[CYCLE_W-1:0];
                REG_PERIOD:  period_reg      <= pwdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads, zero-extended.
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_BEGIN:   prdata[POT_W-1:0]    = begin_pot_reg;
            REG_VERTEX1: prdata[POT_W-1:0]    = vertex1_reg;
            REG_VERTEX2: prdata[POT_W-1:0]    = vertex2_reg;
            REG_STEP:    prdata[STEP_W-1:0]   = step_reg;
            REG_CYCLES:  prdata[CYCLE_W-1:0]  = cycle_total_reg;
            REG_PERIOD:  prdata[PERIOD_W-1:0] = period_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.begin_pot   = begin_pot_reg;
    assign cfg.vertex1     = vertex1_reg;
    assign cfg.vertex2     = vertex2_reg;
    assign cfg.step        = step_reg;
    assign cfg.cycle_total = cycle_total_reg;

    cvs_step u_step (
        .cfg       (cfg),
        .sweep_cur (sweep_reg),
        .sweep_nxt (tick_sweep),
        .finish    (tick_finish)
    );

    // Elapsed time of the point, saturating at the counter range.
    assign time_prod = period_reg * point_count_reg;
    assign time_sat  = (|time_prod[PROD_W-1:COUNT_W]) ? '1 : time_prod[COUNT_W-1:0];

    assign voltage_in = s_tdata[S_OFF_VOLT +: SAMPLE_W];
    assign current_in = s_tdata[S_OFF_CURR +: SAMPLE_W];

    // A beat is taken whenever the result register is free or being emptied.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Next sweep state and result beat for the beat on the input.
    always_comb begin
        sweep_next       = sweep_reg;
        point_count_next = point_count_reg;
        running_next     = running_reg;
        m_tdata_next     = '0;
        m_tuser_next     = 1'b0;
        m_tlast_next     = 1'b0;
        m_tdata_next[M_OFF_SETPOINT +: POT_W] = sweep_reg.setpoint;

        if (s_tuser[0] == CMD_START) begin
            sweep_next.setpoint    = begin_pot_reg;
            sweep_next.sel         = SEL_VERTEX1;
            sweep_next.going_up    = ($signed(vertex1_reg) > $signed(vertex2_reg));
            sweep_next.cycle_index = CYCLE_W'(1);
            point_count_next       = '0;
            running_next           = 1'b1;
            m_tdata_next[M_OFF_SETPOINT +: POT_W] = begin_pot_reg;
        end else if (running_reg) begin
            sweep_next       = tick_sweep;
            point_count_next = point_count_reg + 1'b1;
            running_next     = !tick_finish;
            m_tuser_next     = 1'b1;
            m_tlast_next     = tick_finish;
            m_tdata_next[M_OFF_SETPOINT +: POT_W]  = tick_sweep.setpoint;
            m_tdata_next[M_OFF_INDEX +: COUNT_W]   = point_count_reg;
            m_tdata_next[M_OFF_TIME +: COUNT_W]    = time_sat;
            m_tdata_next[M_OFF_VOLT +: SAMPLE_W]   = voltage_in;
            m_tdata_next[M_OFF_CURR +: SAMPLE_W]   = current_in;
        end
    end

    // Sweep state update on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg.setpoint    <= '0;
            sweep_reg.sel         <= SEL_VERTEX1;
            sweep_reg.going_up    <= 1'b0;
            sweep_reg.cycle_index <= CYCLE_W'(1);
            point_count_reg       <= '0;
            running_reg           <= 1'b0;
        end else if (s_accept) begin
            sweep_reg       <= sweep_next;
            point_count_reg <= point_count_next;
            running_reg     <= running_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

>>> rtl/cvs_step.sv
// Next sweep position for one tick: target changes, direction, cycle count and clamped step.
// Depends on cvs_pkg.
module cvs_step (
    input  cvs_pkg::cvs_cfg_t   cfg,
    input  cvs_pkg::cvs_sweep_t sweep_cur,
    output cvs_pkg::cvs_sweep_t sweep_nxt,
    output logic                finish
);
    import cvs_pkg::*;

    localparam int EXT_W = ((POT_W > STEP_W) ? POT_W : STEP_W) + 2;

    localparam logic signed [EXT_W-1:0] POT_MAX_X =
        {{(EXT_W - POT_W + 1){1'b0}}, {(POT_W - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] POT_MIN_X =
        {{(EXT_W - POT_W + 1){1'b1}}, {(POT_W - 1){1'b0}}};

    logic                     eq_v1;
    logic                     eq_v2;
    logic                     eq_begin;
    logic                     at_last_cycle;
    logic                     do_step;
    logic                     enter_begin;
    logic                     up_begin;
    logic [1:0]               sel_begin;
    logic [POT_W-1:0]         target;
    logic signed [EXT_W-1:0]  cur_x;
    logic signed [EXT_W-1:0]  tgt_x;
    logic signed [EXT_W-1:0]  step_x;
    logic signed [EXT_W-1:0]  moved_x;
    logic signed [EXT_W-1:0]  bounded_x;

    // Exact matches against the three turning potentials.
    assign eq_v1         = (sweep_cur.setpoint == cfg.vertex1);
    assign eq_v2         = (sweep_cur.setpoint == cfg.vertex2);
    assign eq_begin      = (sweep_cur.setpoint == cfg.begin_pot);
    assign at_last_cycle = (sweep_cur.cycle_index >= cfg.cycle_total);

    // Walk the target chain in closed form. Coinciding targets are passed in one tick;
    // when all three coincide the sweep skips its remaining cycles and finishes at once.
    always_comb begin
        sweep_nxt   = sweep_cur;
        finish      = 1'b0;
        do_step     = 1'b0;
        enter_begin = 1'b0;
        up_begin    = sweep_cur.going_up;
        target      = cfg.vertex1;
        sel_begin   = SEL_BEGIN;

        case (sweep_cur.sel)
            SEL_VERTEX1: begin
                if (!eq_v1) begin
                    do_step = 1'b1;
                    target  = cfg.vertex1;
                end else if (!eq_v2) begin
                    sweep_nxt.sel      = SEL_VERTEX2;
                    sweep_nxt.going_up = ~sweep_cur.going_up;
                    do_step            = 1'b1;
                    target             = cfg.vertex2;
                end else begin
                    enter_begin = 1'b1;
                    up_begin    = sweep_cur.going_up;
                end
            end
            SEL_VERTEX2: begin
                if (!eq_v2) begin
                    do_step = 1'b1;
                    target  = cfg.vertex2;
                end else begin
                    enter_begin = 1'b1;
                    up_begin    = ~sweep_cur.going_up;
                end
            end
            default: begin
                enter_begin = 1'b1;
                up_begin    = sweep_cur.going_up;
                sel_begin   = sweep_cur.sel;
            end
        endcase

        // Heading for, or sitting on, the begin potential.
        if (enter_begin) begin
            sweep_nxt.sel      = sel_begin;
            sweep_nxt.going_up = up_begin;
            if (!eq_begin) begin
                do_step = 1'b1;
                target  = cfg.begin_pot;
            end else if (at_last_cycle) begin
                finish = 1'b1;
            end else begin
                sweep_nxt.cycle_index = sweep_cur.cycle_index + 1'b1;
                if (!eq_v1) begin
                    sweep_nxt.sel = SEL_VERTEX1;
                    do_step       = 1'b1;
                    target        = cfg.vertex1;
                end else if (!eq_v2) begin
                    sweep_nxt.sel      = SEL_VERTEX2;
                    sweep_nxt.going_up = ~up_begin;
                    do_step            = 1'b1;
                    target             = cfg.vertex2;
                end else begin
                    sweep_nxt.sel         = SEL_BEGIN;
                    sweep_nxt.cycle_index = cfg.cycle_total;
                    finish                = 1'b1;
                end
            end
        end

        // One step toward the target, stopping on it and saturating at the code range.
        cur_x   = EXT_W'($signed(sweep_cur.setpoint));
        tgt_x   = EXT_W'($signed(target));
        step_x  = EXT_W'($signed({1'b0, cfg.step}));
        moved_x = sweep_nxt.going_up ? (cur_x + step_x) : (cur_x - step_x);
        bounded_x = moved_x;
        if (sweep_nxt.going_up ? (moved_x > tgt_x) : (moved_x < tgt_x)) begin
            bounded_x = tgt_x;
        end
        if (bounded_x > POT_MAX_X) begin
            bounded_x = POT_MAX_X;
        end
        if (bounded_x < POT_MIN_X) begin
            bounded_x = POT_MIN_X;
        end
        if (do_step) begin
            sweep_nxt.setpoint = bounded_x[POT_W-1:0];
        end
    end

endmodule

>>> rtl/cvs_checker.sv
// Port-level assertions for the sweep generator, bound to its top level.
// Depends on cvs_pkg and cyclic_voltammetry_sweep.
module cvs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [0:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cvs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                     m_tuser,
    input logic                           m_tlast
);
    import cvs_pkg::*;

    // A result beat held back by the sink keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // Every accepted beat shows its result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    // The input is never held off while the result register is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A start beat reports no data point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == CMD_START) |=>
            !m_tuser[0] && !m_tlast && (m_tdata[M_DATA_BITS-1:M_OFF_INDEX] == '0))
        else $error("start beat reported a data point");

    // Only a reported point can end the sweep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("finish flagged without a data point");

endmodule

bind cyclic_voltammetry_sweep cvs_checker u_cvs_checker (.*);
